@@ src/mbet_pkg.sv @@
// Shared types, constants and fixed-point helpers for the escape-time core.
`default_nettype none

package mbet_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 32;
  localparam int unsigned ITER_BITS  = 16;

  localparam int unsigned VW         = 48;
  localparam int unsigned MAG_W      = 47;
  localparam int unsigned HALF       = VW / 2;
  localparam int unsigned PROD_W     = 2 * VW;
  localparam int unsigned SAT_W      = COORD_BITS + VW + 2;
  localparam int unsigned CPROD_W    = COORD_BITS + VW + 1;

  localparam int unsigned PX_W       = 12;
  localparam int unsigned ITER_OUT_W = 16;
  localparam int unsigned IN_W       = 2 * PX_W;
  localparam int unsigned OUT_W      = 64;
  localparam int unsigned PAD_W      = OUT_W - MAG_W - ITER_OUT_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = VW;

  localparam int unsigned PH_W       = 2;
  localparam logic [PH_W-1:0] PH_FIRST = '0;
  localparam logic [PH_W-1:0] PH_LAST  = '1;

  localparam logic signed [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN    = {1'b1, {(VW-1){1'b0}}};
  localparam logic [MAG_W-1:0]     MAG_MAX = '1;

  localparam logic signed [VW-1:0] RST_RE_MIN   = -48'sd8589934592;
  localparam logic signed [VW-1:0] RST_IM_MIN   = -48'sd6442450944;
  localparam logic signed [VW-1:0] RST_RE_STEP  = 48'sd34730194;
  localparam logic signed [VW-1:0] RST_IM_STEP  = 48'sd28825284;
  localparam logic [15:0]          RST_MAX_ITER = 16'd32;
  localparam logic [MAG_W-1:0]     RST_ESC_SQ   = 47'd4398046511104;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RE_MIN    = 3'd0,
    CFG_IM_MIN    = 3'd1,
    CFG_RE_STEP   = 3'd2,
    CFG_IM_STEP   = 3'd3,
    CFG_MAX_ITER  = 3'd4,
    CFG_ESCAPE_SQ = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CADD,
    ST_ABS,
    ST_MUL,
    ST_FIN,
    ST_TEST,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic            load_in;
    logic            coord_mul;
    logic            coord_add;
    logic            load_abs;
    logic            mul_en;
    logic [PH_W-1:0] phase;
    logic            fin;
    logic            update;
    logic            out_load;
    logic            out_esc;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic last_iter;
    logic escape;
  } dp_sts_t;

  // Clamp a wide signed value to the 48-bit signed range.
  function automatic logic signed [VW-1:0] sat_vw(input logic signed [SAT_W-1:0] v);
    logic top_ones;
    logic top_zeros;
    top_ones  = &v[SAT_W-1:VW-1];
    top_zeros = ~(|v[SAT_W-1:VW-1]);
    if (top_ones || top_zeros) return v[VW-1:0];
    return v[SAT_W-1] ? VMIN : VMAX;
  endfunction

  // Turn an unsigned magnitude product into a floor-rounded, saturated signed value.
  function automatic logic signed [VW-1:0] fix_round(input logic [PROD_W-1:0] p,
                                                     input logic neg,
                                                     input int unsigned sh);
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] lo_mask;
    logic              rem;
    logic [VW-1:0]     qm;
    q       = p >> sh;
    lo_mask = (PROD_W'(1) << sh) - PROD_W'(1);
    rem     = |(p & lo_mask);
    qm      = q[VW-1:0] + VW'(rem);
    if (|q[PROD_W-1:VW-1]) return neg ? VMIN : VMAX;
    // round a negative result toward minus infinity; a positive one just truncates
    if (neg) return -qm;
    return q[VW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/mbet_dp.sv @@
// Datapath: configuration registers, coordinate mapping, split multipliers and z update.
`default_nettype none

module mbet_dp import mbet_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [IN_W-1:0]       in_data_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  output logic [OUT_W-1:0]           out_data_o,
  output logic                       out_esc_o
);

  logic signed [VW-1:0]      re_min_q, im_min_q, re_step_q, im_step_q;
  logic [15:0]               max_iter_q;
  logic [MAG_W-1:0]          escape_sq_q;

  logic [COORD_BITS-1:0]     px_q, py_q;
  logic signed [CPROD_W-1:0] cprod_re_q, cprod_im_q;
  logic signed [VW-1:0]      c_re_q, c_im_q, re_q, im_q;
  logic signed [VW-1:0]      c_re_d, c_im_d, re_d, im_d;
  logic [VW-1:0]             re_abs_q, im_abs_q;
  logic                      ri_neg_q;
  logic [PROD_W-1:0]         acc_rr_q, acc_ii_q, acc_ri_q;
  logic [PROD_W-1:0]         acc_rr_d, acc_ii_d, acc_ri_d;
  logic signed [VW-1:0]      r2_q, i2_q, ri_q;
  logic [ITER_BITS-1:0]      iter_q, limit;
  logic [VW-1:0]             mag_raw;
  logic [MAG_W-1:0]          mag_sat;
  logic [HALF-1:0]           a_re, b_re, a_im, b_im;
  logic [VW-1:0]             pp_rr, pp_ii, pp_ri;
  logic                      out_esc_q;
  logic [ITER_OUT_W-1:0]     out_iter_q;
  logic [MAG_W-1:0]          out_mag_q;

  function automatic logic [PROD_W-1:0] place(input logic [VW-1:0] pp,
                                              input logic [PH_W-1:0] ph);
    logic [PROD_W-1:0] w;
    w = PROD_W'(pp);
    case (ph)
      2'd0:    return w;
      2'd1:    return w << HALF;
      2'd2:    return w << HALF;
      2'd3:    return w << VW;
      default: return w;
    endcase
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_min_q    <= RST_RE_MIN;
      im_min_q    <= RST_IM_MIN;
      re_step_q   <= RST_RE_STEP;
      im_step_q   <= RST_IM_STEP;
      max_iter_q  <= RST_MAX_ITER;
      escape_sq_q <= RST_ESC_SQ;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RE_MIN:    re_min_q    <= cfg_data_i;
        CFG_IM_MIN:    im_min_q    <= cfg_data_i;
        CFG_RE_STEP:   re_step_q   <= cfg_data_i;
        CFG_IM_STEP:   im_step_q   <= cfg_data_i;
        CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[15:0];
        CFG_ESCAPE_SQ: escape_sq_q <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = ITER_BITS'(max_iter_q);

  // Quarter products: high or low half of each operand, picked by phase
  always_comb begin
    a_re  = cmd_i.phase[1] ? re_abs_q[VW-1:HALF] : re_abs_q[HALF-1:0];
    b_re  = cmd_i.phase[0] ? re_abs_q[VW-1:HALF] : re_abs_q[HALF-1:0];
    a_im  = cmd_i.phase[1] ? im_abs_q[VW-1:HALF] : im_abs_q[HALF-1:0];
    b_im  = cmd_i.phase[0] ? im_abs_q[VW-1:HALF] : im_abs_q[HALF-1:0];
    pp_rr = a_re * b_re;
    pp_ii = a_im * b_im;
    pp_ri = a_re * b_im;
    acc_rr_d = ((cmd_i.phase == PH_FIRST) ? '0 : acc_rr_q) + place(pp_rr, cmd_i.phase);
    acc_ii_d = ((cmd_i.phase == PH_FIRST) ? '0 : acc_ii_q) + place(pp_ii, cmd_i.phase);
    acc_ri_d = ((cmd_i.phase == PH_FIRST) ? '0 : acc_ri_q) + place(pp_ri, cmd_i.phase);
  end

  always_comb begin
    c_re_d  = sat_vw(SAT_W'(re_min_q) + SAT_W'(cprod_re_q));
    c_im_d  = sat_vw(SAT_W'(im_min_q) + SAT_W'(cprod_im_q));
    re_d    = sat_vw(SAT_W'(r2_q) - SAT_W'(i2_q) + SAT_W'(c_re_q));
    im_d    = sat_vw(SAT_W'(ri_q) + SAT_W'(c_im_q));
    mag_raw = $unsigned(r2_q) + $unsigned(i2_q);
    mag_sat = mag_raw[VW-1] ? MAG_MAX : mag_raw[MAG_W-1:0];
  end

  always_comb begin
    sts_o.limit_zero = (limit == '0);
    sts_o.last_iter  = ({1'b0, iter_q} + (ITER_BITS+1)'(1)) == {1'b0, limit};
    sts_o.escape     = (mag_sat > escape_sq_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      px_q <= COORD_BITS'(in_data_i[PX_W-1:0]);
      py_q <= COORD_BITS'(in_data_i[IN_W-1:PX_W]);
    end
    if (cmd_i.coord_mul) begin
      cprod_re_q <= $signed({1'b0, px_q}) * re_step_q;
      cprod_im_q <= $signed({1'b0, py_q}) * im_step_q;
    end
    if (cmd_i.coord_add) begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
      re_q   <= c_re_d;
      im_q   <= c_im_d;
      iter_q <= '0;
    end
    if (cmd_i.load_abs) begin
      re_abs_q <= re_q[VW-1] ? -re_q : re_q;
      im_abs_q <= im_q[VW-1] ? -im_q : im_q;
      ri_neg_q <= re_q[VW-1] ^ im_q[VW-1];
    end
    if (cmd_i.mul_en) begin
      acc_rr_q <= acc_rr_d;
      acc_ii_q <= acc_ii_d;
      acc_ri_q <= acc_ri_d;
    end
    if (cmd_i.fin) begin
      r2_q <= fix_round(acc_rr_q, 1'b0, FRAC_BITS);
      i2_q <= fix_round(acc_ii_q, 1'b0, FRAC_BITS);
      ri_q <= fix_round(acc_ri_q, ri_neg_q, FRAC_BITS - 1);
    end
    if (cmd_i.update) begin
      re_q   <= re_d;
      im_q   <= im_d;
      iter_q <= iter_q + ITER_BITS'(1);
    end
    if (cmd_i.out_load) begin
      out_esc_q  <= cmd_i.out_esc;
      out_iter_q <= ITER_OUT_W'(iter_q);
      out_mag_q  <= cmd_i.out_esc ? mag_sat : '0;
    end
  end

  assign out_data_o = {{PAD_W{1'b0}}, out_mag_q, out_iter_q};
  assign out_esc_o  = out_esc_q;

endmodule

`default_nettype wire

@@ src/mbet_ctrl.sv @@
// Controller: sequences coordinate setup, multiply phases, escape test and result hand-off.
`default_nettype none

module mbet_ctrl import mbet_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e     state_q, state_d;
  logic [PH_W-1:0] phase_q, phase_d;
  logic            esc_q, esc_d;
  logic            m_valid_q, m_valid_d;
  logic            slot_free;

  assign slot_free = !m_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    phase_d = PH_FIRST;
    esc_d   = esc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMUL;
      end
      ST_CMUL: state_d = ST_CADD;
      ST_CADD: begin
        esc_d   = 1'b0;
        state_d = sts_i.limit_zero ? ST_EMIT : ST_ABS;
      end
      ST_ABS:  state_d = ST_MUL;
      ST_MUL: begin
        phase_d = phase_q + PH_W'(1);
        if (phase_q == PH_LAST) state_d = ST_FIN;
      end
      ST_FIN:  state_d = ST_TEST;
      ST_TEST: begin
        esc_d = sts_i.escape;
        if (sts_i.escape || sts_i.last_iter) state_d = ST_EMIT;
        else state_d = ST_ABS;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.phase     = phase_q;
    cmd_o.out_esc   = esc_q;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_CMUL: cmd_o.coord_mul = 1'b1;
      ST_CADD: cmd_o.coord_add = 1'b1;
      ST_ABS:  cmd_o.load_abs  = 1'b1;
      ST_MUL:  cmd_o.mul_en    = 1'b1;
      ST_FIN:  cmd_o.fin       = 1'b1;
      ST_TEST: cmd_o.update    = !sts_i.escape;
      ST_EMIT: cmd_o.out_load  = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) m_valid_d = 1'b1;
    else if (out_ready_i) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_FIRST;
      esc_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      esc_q     <= esc_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign out_valid_o = m_valid_q;

  a_escape_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST && sts_i.escape) |=> (state_q == ST_EMIT && esc_q))
    else $error("escape test did not lead to result hand-off");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!m_valid_q || out_ready_i))
    else $error("result register overwritten while occupied");

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_MUL) |-> (phase_q == PH_FIRST))
    else $error("multiply phase left nonzero outside multiply state");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_CMUL))
    else $error("accepted word did not start coordinate setup");

endmodule

`default_nettype wire

@@ src/mandelbrot_escape_time_core.sv @@
// Top level: Mandelbrot escape-time evaluator with stream ports and register write port.
// Steps run per pixel: escape at step k runs k+1 steps, no escape runs max_iter,
//   and a zero limit runs none, going from coordinate setup straight to hand-off.
// Each step has operand magnitude, four quarter-product phases of the three
//   24x24 multipliers, round/saturate, then escape test and z update.
// One pixel at a time; the output register holds a result while the next pixel runs.
// Reset: asynchronous active low; returns to idle, output empty, registers to defaults.
`default_nettype none

module mandelbrot_escape_time_core import mbet_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,  // pixel_x, pixel_y
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata,  // iter_count, final_mag_sq, zero pad
  output logic [0:0]                 m_axis_tuser   // escaped
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_esc;

  assign cfg_ready_o = 1'b1;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata),
    .out_esc_o   (out_esc)
  );

  assign m_axis_tuser = out_esc;

endmodule

`default_nettype wire

@@ tb/sv/mbet_tb_pkg.sv @@
// Escape-time predictor and result scoreboard for the escape-time core testbench.
`timescale 1ns / 100ps

package mbet_tb_pkg;
  import mbet_pkg::*;

  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam longint S48_MAX = (longint'(1) << (VW - 1)) - 1;
  localparam longint S48_MIN = -S48_MAX - 1;
  localparam longint MAG_TOP = S48_MAX;

  typedef struct packed {
    logic signed [VW-1:0]  re_min;
    logic signed [VW-1:0]  im_min;
    logic signed [VW-1:0]  re_step;
    logic signed [VW-1:0]  im_step;
    logic [ITER_OUT_W-1:0] max_iter;
    logic [MAG_W-1:0]      escape_sq;
  } view_cfg_t;

  typedef struct packed {
    logic                  escaped;
    logic [ITER_OUT_W-1:0] iter_count;
    logic [MAG_W-1:0]      final_mag_sq;
  } escape_result_t;

  class escape_scoreboard;
    view_cfg_t      view;
    escape_result_t expected_escapes[$];
    int unsigned    n_pixels;
    int unsigned    n_results;
    int unsigned    n_escaped;
    int unsigned    n_errors;

    function new();
      view.re_min    = VW'(-2 * ONE);
      view.im_min    = VW'(-3 * ONE / 2);
      view.re_step   = VW'(longint'(34730194));
      view.im_step   = VW'(longint'(28825284));
      view.max_iter  = 16'd32;
      view.escape_sq = MAG_W'(1024 * ONE);
      n_pixels  = 0;
      n_results = 0;
      n_escaped = 0;
      n_errors  = 0;
    endfunction

    function longint clamp48(input longint v);
      if (v > S48_MAX) return S48_MAX;
      if (v < S48_MIN) return S48_MIN;
      return v;
    endfunction

    // Exact product, floor-shifted right by sh, clamped to 48-bit signed.
    function longint fix_mul(input longint a, input longint b, input int unsigned sh);
      logic [VW-1:0]     ua;
      logic [VW-1:0]     ub;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] quo;
      logic              rem;
      logic              neg;
      neg  = (a < 0) != (b < 0);
      ua   = (a < 0) ? VW'(-a) : VW'(a);
      ub   = (b < 0) ? VW'(-b) : VW'(b);
      prod = {{VW{1'b0}}, ua} * {{VW{1'b0}}, ub};
      quo  = prod >> sh;
      rem  = |(prod & ((PROD_W'(1) << sh) - PROD_W'(1)));
      if (|quo[PROD_W-1:VW-1]) return neg ? S48_MIN : S48_MAX;
      if (neg) return -(longint'(quo[VW-2:0]) + longint'(rem));
      return longint'(quo[VW-2:0]);
    endfunction

    function escape_result_t predict_escape(input logic [PX_W-1:0] px,
                                            input logic [PX_W-1:0] py);
      escape_result_t res;
      longint         c_re;
      longint         c_im;
      longint         zr;
      longint         zi;
      longint         r2;
      longint         i2;
      longint         mag;
      int unsigned    k;
      c_re = clamp48(longint'(view.re_min) + longint'(px) * longint'(view.re_step));
      c_im = clamp48(longint'(view.im_min) + longint'(py) * longint'(view.im_step));
      zr   = c_re;
      zi   = c_im;
      res  = '0;
      res.iter_count = view.max_iter;
      for (k = 0; k < view.max_iter; k++) begin
        r2  = fix_mul(zr, zr, FRAC_BITS);
        i2  = fix_mul(zi, zi, FRAC_BITS);
        mag = r2 + i2;
        if (mag > MAG_TOP) mag = MAG_TOP;
        if (mag > longint'(view.escape_sq)) begin
          res.escaped      = 1'b1;
          res.iter_count   = ITER_OUT_W'(k);
          res.final_mag_sq = MAG_W'(mag);
          return res;
        end
        // imaginary part first: it needs the old real part
        zi = clamp48(fix_mul(zr, zi, FRAC_BITS - 1) + c_im);
        zr = clamp48(r2 - i2 + c_re);
      end
      return res;
    endfunction

    function void note_pixel(input logic [PX_W-1:0] px, input logic [PX_W-1:0] py);
      expected_escapes.push_back(predict_escape(px, py));
      n_pixels++;
    endfunction

    function int pending_count();
      return expected_escapes.size();
    endfunction

    task report_mismatch(input string field, input longint unsigned got,
                         input longint unsigned want);
      $display("%0t result %0d: %s is 0x%0h, expected 0x%0h",
               $time, n_results, field, got, want);
      n_errors++;
    endtask

    task check_result(input logic [OUT_W-1:0] data, input logic escaped);
      escape_result_t want;
      n_results++;
      if (expected_escapes.size() == 0) begin
        report_mismatch("word with no pixel pending, tdata", data, 0);
        return;
      end
      want = expected_escapes.pop_front();
      if (want.escaped) n_escaped++;
      if (escaped !== want.escaped)
        report_mismatch("escaped", escaped, want.escaped);
      if (data[ITER_OUT_W-1:0] !== want.iter_count)
        report_mismatch("iter_count", data[ITER_OUT_W-1:0], want.iter_count);
      if (data[ITER_OUT_W +: MAG_W] !== want.final_mag_sq)
        report_mismatch("final_mag_sq", data[ITER_OUT_W +: MAG_W], want.final_mag_sq);
      if (data[OUT_W-1 -: PAD_W] !== '0)
        report_mismatch("pad bits", data[OUT_W-1 -: PAD_W], 0);
    endtask
  endclass

endpackage

@@ tb/sv/mandelbrot_escape_time_core_tb.sv @@
// Testbench top: drives pixels and register writes into the escape-time core and checks results.
`timescale 1ns / 100ps

module mandelbrot_escape_time_core_tb;
  import mbet_pkg::*;
  import mbet_tb_pkg::*;

  localparam int unsigned RUN_LIMIT    = 2_000_000;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_PIXELS = 200;
  localparam int unsigned VIEW_ITER    = 24;
  localparam logic [PX_W-1:0] PX_TOP   = '1;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  escape_scoreboard sb = new();
  bit               gaps_on     = 1'b1;
  int unsigned      n_settings  = 0;
  int unsigned      cycle_count = 0;

  mandelbrot_escape_time_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** mandelbrot_escape_time_core: FAILED **");
    $finish;
  end

  // Result side: check every accepted word, then, while gaps are on, may stall a random number of cycles.
  initial begin : result_side
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        hold = gaps_on ? $urandom_range(0, 8) : 0;
        if (hold != 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_pixel(input logic [PX_W-1:0] px, input logic [PX_W-1:0] py);
    int unsigned hold;
    hold = gaps_on ? $urandom_range(0, 8) : 0;
    if (hold != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    s_axis_tdata  <= {py, px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px, py);
  endtask

  // Drop valid and hold until every pending pixel has come back.
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  task automatic write_config(input longint re_min, input longint im_min,
                              input longint re_step, input longint im_step,
                              input int unsigned iter_limit, input longint esc_sq);
    view_cfg_t             v;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    int                    r;
    v.re_min    = VW'(re_min);
    v.im_min    = VW'(im_min);
    v.re_step   = VW'(re_step);
    v.im_step   = VW'(im_step);
    v.max_iter  = ITER_OUT_W'(iter_limit);
    v.escape_sq = MAG_W'(esc_sq);
    for (r = CFG_RE_MIN; r <= CFG_ESCAPE_SQ; r++) begin
      idx = cfg_reg_e'(r);
      case (idx)
        CFG_RE_MIN:    data = v.re_min;
        CFG_IM_MIN:    data = v.im_min;
        CFG_RE_STEP:   data = v.re_step;
        CFG_IM_STEP:   data = v.im_step;
        CFG_MAX_ITER:  data = CFG_DATA_W'(v.max_iter);
        CFG_ESCAPE_SQ: data = CFG_DATA_W'(v.escape_sq);
        default:       data = '0;
      endcase
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    sb.view = v;
    n_settings++;
  endtask

  // Either a window over the set with random placement, or raw register noise.
  task automatic write_random_view(input bit noisy);
    longint      rm;
    longint      imn;
    longint      rs;
    longint      ist;
    longint      esc;
    int unsigned lim;
    if (noisy) begin
      rm  = longint'({$urandom, $urandom});
      imn = longint'({$urandom, $urandom});
      rs  = $urandom_range(0, 1) ? longint'({$urandom, $urandom}) : longint'(int'($urandom));
      ist = $urandom_range(0, 1) ? longint'({$urandom, $urandom}) : longint'(int'($urandom));
      lim = $urandom_range(0, 8);
      esc = longint'({$urandom, $urandom}) >> $urandom_range(17, 63);
    end else begin
      rm  = -(5 * ONE / 2) + longint'($urandom_range(0, 2_000_000_000));
      imn = -(3 * ONE / 2) + longint'($urandom_range(0, 1_000_000_000));
      rs  = longint'($urandom_range(1_000_000, 4_000_000));
      ist = longint'($urandom_range(1_000_000, 4_000_000));
      // mirror the window about the real axis
      if ($urandom_range(0, 1)) begin
        imn = -imn;
        ist = -ist;
      end
      lim = $urandom_range(1, VIEW_ITER);
      esc = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 4096)) << 30 : 4 * ONE;
    end
    write_config(rm, imn, rs, ist, lim, esc);
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: corners, a point near the origin that never escapes, and one more point
    send_pixel('0, '0);
    send_pixel(PX_TOP, PX_TOP);
    send_pixel(PX_TOP, '0);
    send_pixel('0, PX_TOP);
    send_pixel(12'd248, 12'd223);
    send_pixel(12'd150, 12'd100);
    wait_all_results();

    // clamped coordinates with a zero iteration limit
    write_config(S48_MAX, S48_MIN, S48_MAX, S48_MIN, 0, 0);
    send_pixel(PX_TOP, PX_TOP);
    send_pixel('0, '0);
    send_pixel(12'd1, 12'd1);
    wait_all_results();

    // full iteration limit, zero radius: escape on the first test
    write_config(3 * ONE, S48_MIN, 0, S48_MAX, 65535, 0);
    send_pixel('0, '0);
    send_pixel(PX_TOP, PX_TOP);
    send_pixel(12'd3, 12'd1);
    wait_all_results();

    // radius at the top of the magnitude range: nothing escapes
    write_config(S48_MIN, S48_MAX, -1, 1, 5, MAG_TOP);
    send_pixel('0, '0);
    send_pixel(PX_TOP, PX_TOP);
    wait_all_results();

    // unit grid: a magnitude equal to the radius does not escape; (0, 0) escapes on the last allowed step
    write_config(ONE, 0, ONE, ONE, 3, 4 * ONE);
    send_pixel('0, '0);
    send_pixel(12'd1, '0);
    send_pixel('0, 12'd1);
    send_pixel(PX_TOP, PX_TOP);

    for (p = 0; p < N_PHASES; p++) begin
      wait_all_results();
      gaps_on = (p % 3 != 1);
      write_random_view(p == 3 || p == 6);
      for (k = 0; k < PHASE_PIXELS; k++) begin
        if (k == PHASE_PIXELS / 2 || $urandom_range(0, 63) == 0) wait_all_results();
        send_pixel(PX_W'($urandom_range(0, 4095)), PX_W'($urandom_range(0, 4095)));
      end
    end

    wait_all_results();
    // let a stray extra word show up before closing
    repeat (7 * VIEW_ITER + 4) @(posedge clk_i);
    $display("Checked %0d results for %0d pixels under %0d register settings, %0d escaped.",
             sb.n_results, sb.n_pixels, n_settings, sb.n_escaped);
    $display("Settings covered zero and full iteration limits, clamped coordinates and radii.");
    if (sb.n_errors == 0) begin
      $display("** mandelbrot_escape_time_core: PASSED **");
    end else begin
      $display("** mandelbrot_escape_time_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/mbet_pkg.sv
src/mbet_dp.sv
src/mbet_ctrl.sv
src/mandelbrot_escape_time_core.sv
tb/sv/mbet_tb_pkg.sv
tb/sv/mandelbrot_escape_time_core_tb.sv
